// ----- hdl/msbot_pkg.sv -----
// shared types and constants for the bulk-only transport sequencer
// no dependencies; used by the register block, the top level, the checker and the testbench
package msbot_pkg;

  localparam logic [31:0] CBW_SIGNATURE     = 32'h4342_5355;
  localparam logic [31:0] CSW_SIGNATURE     = 32'h5342_5355;
  localparam logic [6:0]  CBW_RESERVED_MASK = 7'h7f;
  localparam int unsigned CBW_DIR_IN_BIT    = 7;
  localparam logic [15:0] CBW_SIZE          = 16'd31;
  localparam logic [15:0] CSW_SIZE          = 16'd13;
  localparam logic [7:0]  MAX_CB_LENGTH     = 8'd16;
  localparam logic [7:0]  REQ_BOMSR         = 8'hff;
  localparam logic [7:0]  REQ_GET_MAX_LUN   = 8'hfe;
  localparam logic [7:0]  TYPE_CLASS_OUT    = 8'h21;
  localparam logic [7:0]  TYPE_CLASS_IN     = 8'ha1;

  localparam logic [15:0] IN_CHUNK_LIMIT_RESET = 16'd512;

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    OP_SETUP    = 2'd0,
    OP_BULK_OUT = 2'd1,
    OP_BULK_IN  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_COMMAND  = 3'd0,
    PH_DATA_OUT = 3'd1,
    PH_DATA_IN  = 3'd2,
    PH_FAIL_OUT = 3'd3,
    PH_FAIL_IN  = 3'd4,
    PH_STATUS   = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE          = 4'd0,
    ACT_RESET_ACK     = 4'd1,
    ACT_LUN_REPLY     = 4'd2,
    ACT_COMMAND       = 4'd3,
    ACT_OUT_FORWARDED = 4'd4,
    ACT_OUT_DISCARDED = 4'd5,
    ACT_IN_DATA       = 4'd6,
    ACT_IN_FILLER     = 4'd7,
    ACT_STATUS        = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    REG_INTERFACE_NUMBER = 2'd0,
    REG_MAX_LUN          = 2'd1,
    REG_IN_CHUNK_LIMIT   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  interface_number;
    logic [3:0]  max_lun;
    logic [15:0] in_chunk_limit;
  } cfg_t;

endpackage

// ----- hdl/msbot_req_if.sv -----
// input item channel: valid/ready handshake with the event fields
// depends on nothing
interface msbot_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] setup_head;
  logic [15:0] setup_value;
  logic [15:0] setup_index;
  logic [15:0] length;
  logic [31:0] cbw_signature;
  logic [31:0] cbw_tag;
  logic [31:0] cbw_transfer_length;
  logic [7:0]  cbw_flags;
  logic [7:0]  cbw_lun;
  logic [7:0]  cbw_block_length;
  logic        handler_ok;

  modport source (
    output valid, op, setup_head, setup_value, setup_index, length, cbw_signature,
           cbw_tag, cbw_transfer_length, cbw_flags, cbw_lun, cbw_block_length, handler_ok,
    input  ready
  );

  modport sink (
    input  valid, op, setup_head, setup_value, setup_index, length, cbw_signature,
           cbw_tag, cbw_transfer_length, cbw_flags, cbw_lun, cbw_block_length, handler_ok,
    output ready
  );
endinterface

// ----- hdl/msbot_rsp_if.sv -----
// result item channel: valid/ready handshake with the result fields
// depends on nothing
interface msbot_rsp_if;
  logic        valid;
  logic        ready;
  logic        handled;
  logic [3:0]  action;
  logic [7:0]  reply_byte;
  logic [15:0] chunk_length;
  logic [3:0]  handler_lun;
  logic [31:0] csw_signature;
  logic [31:0] csw_tag;
  logic [31:0] csw_residue;
  logic        csw_status;

  modport source (
    output valid, handled, action, reply_byte, chunk_length, handler_lun, csw_signature,
           csw_tag, csw_residue, csw_status,
    input  ready
  );

  modport sink (
    input  valid, handled, action, reply_byte, chunk_length, handler_lun, csw_signature,
           csw_tag, csw_residue, csw_status,
    output ready
  );
endinterface

// ----- hdl/msbot_regs.sv -----
// apb configuration registers: interface number, max lun, max bulk-in chunk size
// depends on msbot_pkg
module msbot_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msbot_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output msbot_pkg::cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interface_number <= 8'd0;
      cfg.max_lun          <= 4'd0;
      cfg.in_chunk_limit   <= msbot_pkg::IN_CHUNK_LIMIT_RESET;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        msbot_pkg::REG_INTERFACE_NUMBER: cfg.interface_number <= pwdata[7:0];
        msbot_pkg::REG_MAX_LUN:          cfg.max_lun          <= pwdata[3:0];
        msbot_pkg::REG_IN_CHUNK_LIMIT:   cfg.in_chunk_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        msbot_pkg::REG_INTERFACE_NUMBER: prdata = {24'd0, cfg.interface_number};
        msbot_pkg::REG_MAX_LUN:          prdata = {28'd0, cfg.max_lun};
        msbot_pkg::REG_IN_CHUNK_LIMIT:   prdata = {16'd0, cfg.in_chunk_limit};
        default:                         prdata = 32'd0;
      endcase
    end
  end

endmodule

// ----- hdl/mass_storage_bulk_only_transport.sv -----
// device-side usb mass storage bulk-only transport sequencer, top level
// depends on msbot_pkg, msbot_req_if, msbot_rsp_if and msbot_regs
//
// usage:
//   req carries one event per item: a control setup request, a bulk-out packet
//   (command wrapper or data chunk) or a free bulk-in slot, with the handler's
//   pass/fail flag for that event. rsp returns exactly one result item per
//   event: handled flag, action code, reply byte, bulk-in chunk length, handler
//   lun and, for the status action, the status wrapper fields.
//   the apb port sets interface number (0x0), max lun (0x4) and max bulk-in
//   chunk size (0x8); write it only while no item is in flight.
// the result is registered and appears on rsp in the cycle after the item is accepted.
// throughput: one item per cycle while results are taken; all decoding, the 32-bit
//   length subtract and the chunk-size compare sit between the phase/state registers
//   and the single result register.
// reset: the sequencer waits for a command wrapper, saved tag, lun, residue and
//   lengths are cleared, no result is pending, registers return to defaults.
// stall: while a result waits and rsp.ready is low, req.ready drops; when the
//   result is taken a new item is accepted in the same cycle.
module mass_storage_bulk_only_transport (
  input  logic                          clk,
  input  logic                          rst,
  msbot_req_if.sink                     req,
  msbot_rsp_if.source                   rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msbot_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  msbot_pkg::cfg_t cfg;

  msbot_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msbot_pkg::phase_t phase, phase_next;
  logic [31:0]       saved_tag, saved_tag_next;
  logic [3:0]        saved_lun, saved_lun_next;
  logic [31:0]       residue, residue_next;
  logic [31:0]       remaining_length, remaining_length_next;
  logic              direction_in, direction_in_next;
  logic              success, success_next;

  logic              accept;
  logic              setup_common, setup_reset, setup_lun, cbw_valid;
  logic [31:0]       len_wide, max_in_wide, out_left, chunk, in_left;

  msbot_pkg::action_t r_action;
  logic              r_handled;
  logic [7:0]        r_reply_byte;
  logic [15:0]       r_chunk_length;
  logic [3:0]        r_handler_lun;
  logic [31:0]       r_csw_signature, r_csw_tag, r_csw_residue;
  logic              r_csw_status;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // request decode
  assign setup_common = (req.setup_value == 16'd0) &&
                        (req.setup_index == {8'd0, cfg.interface_number});
  assign setup_reset  = setup_common && req.setup_head[7:0] == msbot_pkg::TYPE_CLASS_OUT &&
                        req.setup_head[15:8] == msbot_pkg::REQ_BOMSR && req.length == 16'd0;
  assign setup_lun    = setup_common && req.setup_head[7:0] == msbot_pkg::TYPE_CLASS_IN &&
                        req.setup_head[15:8] == msbot_pkg::REQ_GET_MAX_LUN &&
                        req.length == 16'd1;
  assign cbw_valid    = req.length == msbot_pkg::CBW_SIZE &&
                        req.cbw_signature == msbot_pkg::CBW_SIGNATURE &&
                        (req.cbw_flags[6:0] & msbot_pkg::CBW_RESERVED_MASK) == 7'd0 &&
                        req.cbw_block_length <= msbot_pkg::MAX_CB_LENGTH &&
                        req.cbw_lun <= {4'd0, cfg.max_lun};

  // length bookkeeping
  assign len_wide    = {16'd0, req.length};
  assign max_in_wide = {16'd0, cfg.in_chunk_limit};
  assign out_left    = (len_wide >= remaining_length) ? 32'd0 : remaining_length - len_wide;
  assign chunk       = (remaining_length > max_in_wide) ? max_in_wide : remaining_length;
  assign in_left     = remaining_length - chunk;

  // next state
  always_comb begin
    phase_next            = phase;
    saved_tag_next        = saved_tag;
    saved_lun_next        = saved_lun;
    residue_next          = residue;
    remaining_length_next = remaining_length;
    direction_in_next     = direction_in;
    success_next          = success;
    case (req.op)
      msbot_pkg::OP_SETUP: begin
        if (setup_reset) begin
          phase_next = msbot_pkg::PH_COMMAND;
        end
      end
      msbot_pkg::OP_BULK_OUT: begin
        case (phase)
          msbot_pkg::PH_COMMAND: begin
            if (cbw_valid) begin
              success_next   = req.handler_ok;
              saved_tag_next = req.cbw_tag;
              saved_lun_next = req.cbw_lun[3:0];
              residue_next   = 32'd0;
              if (req.cbw_transfer_length == 32'd0) begin
                phase_next = msbot_pkg::PH_STATUS;
              end else begin
                direction_in_next     = req.cbw_flags[msbot_pkg::CBW_DIR_IN_BIT];
                remaining_length_next = req.cbw_transfer_length;
                if (req.handler_ok) begin
                  phase_next = req.cbw_flags[msbot_pkg::CBW_DIR_IN_BIT] ?
                               msbot_pkg::PH_DATA_IN : msbot_pkg::PH_DATA_OUT;
                end else begin
                  residue_next = req.cbw_transfer_length;
                  phase_next   = req.cbw_flags[msbot_pkg::CBW_DIR_IN_BIT] ?
                                 msbot_pkg::PH_FAIL_IN : msbot_pkg::PH_FAIL_OUT;
                end
              end
            end
          end
          msbot_pkg::PH_DATA_OUT, msbot_pkg::PH_FAIL_OUT: begin
            if (phase == msbot_pkg::PH_DATA_OUT && !req.handler_ok) begin
              residue_next = remaining_length;
              success_next = 1'b0;
              phase_next   = msbot_pkg::PH_FAIL_OUT;
            end
            remaining_length_next = out_left;
            if (out_left == 32'd0) begin
              phase_next = msbot_pkg::PH_STATUS;
            end
          end
          default: ;
        endcase
      end
      msbot_pkg::OP_BULK_IN: begin
        case (phase)
          msbot_pkg::PH_DATA_IN, msbot_pkg::PH_FAIL_IN: begin
            if (phase == msbot_pkg::PH_DATA_IN && !req.handler_ok) begin
              residue_next = remaining_length;
              success_next = 1'b0;
              phase_next   = msbot_pkg::PH_FAIL_IN;
            end
            remaining_length_next = in_left;
            if (in_left == 32'd0) begin
              phase_next = msbot_pkg::PH_STATUS;
            end
          end
          msbot_pkg::PH_STATUS: begin
            phase_next = msbot_pkg::PH_COMMAND;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    r_handled       = 1'b0;
    r_action        = msbot_pkg::ACT_NONE;
    r_reply_byte    = 8'd0;
    r_chunk_length  = 16'd0;
    r_handler_lun   = 4'd0;
    r_csw_signature = 32'd0;
    r_csw_tag       = 32'd0;
    r_csw_residue   = 32'd0;
    r_csw_status    = 1'b0;
    case (req.op)
      msbot_pkg::OP_SETUP: begin
        if (setup_reset) begin
          r_handled = 1'b1;
          r_action  = msbot_pkg::ACT_RESET_ACK;
        end else if (setup_lun) begin
          r_handled    = 1'b1;
          r_action     = msbot_pkg::ACT_LUN_REPLY;
          r_reply_byte = {4'd0, cfg.max_lun};
        end
      end
      msbot_pkg::OP_BULK_OUT: begin
        case (phase)
          msbot_pkg::PH_COMMAND: begin
            if (cbw_valid) begin
              r_handled     = 1'b1;
              r_action      = msbot_pkg::ACT_COMMAND;
              r_handler_lun = req.cbw_lun[3:0];
            end
          end
          msbot_pkg::PH_DATA_OUT: begin
            r_handled     = 1'b1;
            r_action      = msbot_pkg::ACT_OUT_FORWARDED;
            r_handler_lun = saved_lun;
          end
          msbot_pkg::PH_FAIL_OUT: begin
            r_handled = 1'b1;
            r_action  = msbot_pkg::ACT_OUT_DISCARDED;
          end
          default: ;
        endcase
      end
      msbot_pkg::OP_BULK_IN: begin
        case (phase)
          msbot_pkg::PH_DATA_IN: begin
            r_handled      = 1'b1;
            r_action       = msbot_pkg::ACT_IN_DATA;
            r_chunk_length = chunk[15:0];
            r_handler_lun  = saved_lun;
          end
          msbot_pkg::PH_FAIL_IN: begin
            r_handled      = 1'b1;
            r_action       = msbot_pkg::ACT_IN_FILLER;
            r_chunk_length = chunk[15:0];
          end
          msbot_pkg::PH_STATUS: begin
            r_handled       = 1'b1;
            r_action        = msbot_pkg::ACT_STATUS;
            r_chunk_length  = msbot_pkg::CSW_SIZE;
            r_csw_signature = msbot_pkg::CSW_SIGNATURE;
            r_csw_tag       = saved_tag;
            r_csw_residue   = residue;
            r_csw_status    = !success;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= msbot_pkg::PH_COMMAND;
      saved_tag        <= 32'd0;
      saved_lun        <= 4'd0;
      residue          <= 32'd0;
      remaining_length <= 32'd0;
      direction_in     <= 1'b0;
      success          <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      saved_tag        <= saved_tag_next;
      saved_lun        <= saved_lun_next;
      residue          <= residue_next;
      remaining_length <= remaining_length_next;
      direction_in     <= direction_in_next;
      success          <= success_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.handled       <= r_handled;
      rsp.action        <= r_action;
      rsp.reply_byte    <= r_reply_byte;
      rsp.chunk_length  <= r_chunk_length;
      rsp.handler_lun   <= r_handler_lun;
      rsp.csw_signature <= r_csw_signature;
      rsp.csw_tag       <= r_csw_tag;
      rsp.csw_residue   <= r_csw_residue;
      rsp.csw_status    <= r_csw_status;
    end
  end

endmodule

// ----- hdl/msbot_checker.sv -----
// port-level checks for the bulk-only transport sequencer, bound to the top level
// depends on msbot_pkg and mass_storage_bulk_only_transport
module msbot_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_handled,
  input logic [3:0]  rsp_action,
  input logic [15:0] rsp_chunk_length,
  input logic [31:0] rsp_csw_signature
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action))
    else $error("result item dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result item pending after reset");

  a_unhandled_none: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_handled |-> rsp_action == msbot_pkg::ACT_NONE)
    else $error("unhandled item carries an action");

  a_status_wrapper: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_action == msbot_pkg::ACT_STATUS |->
      rsp_csw_signature == msbot_pkg::CSW_SIGNATURE && rsp_chunk_length == msbot_pkg::CSW_SIZE)
    else $error("status wrapper malformed");

  a_no_stray_wrapper: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_action != msbot_pkg::ACT_STATUS |-> rsp_csw_signature == 32'd0)
    else $error("status signature outside status action");

endmodule

bind mass_storage_bulk_only_transport msbot_checker u_msbot_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_handled       (rsp.handled),
  .rsp_action        (rsp.action),
  .rsp_chunk_length  (rsp.chunk_length),
  .rsp_csw_signature (rsp.csw_signature)
);

// ----- test/mass_storage_bulk_only_transport_tb.sv -----
// self-checking testbench for the bulk-only transport sequencer top level
// needs msbot_pkg, msbot_req_if, msbot_rsp_if and mass_storage_bulk_only_transport
// a phase tracker predicts every result item; host events are driven with random idling
module mass_storage_bulk_only_transport_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] setup_head;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] length;
    logic [31:0] cbw_signature;
    logic [31:0] cbw_tag;
    logic [31:0] cbw_transfer_length;
    logic [7:0]  cbw_flags;
    logic [7:0]  cbw_lun;
    logic [7:0]  cbw_block_length;
    logic        handler_ok;
  } host_event_t;

  typedef struct {
    logic        handled;
    logic [3:0]  action;
    logic [7:0]  reply_byte;
    logic [15:0] chunk_length;
    logic [3:0]  handler_lun;
    logic [31:0] csw_signature;
    logic [31:0] csw_tag;
    logic [31:0] csw_residue;
    logic        csw_status;
  } bot_result_t;

  class bot_phase_tracker;
    msbot_pkg::cfg_t   cfg;
    msbot_pkg::phase_t phase;
    logic [31:0] saved_tag;
    logic [3:0]  saved_lun;
    logic [31:0] residue;
    logic [31:0] remaining;
    logic        direction_in;
    logic        success;
    bot_result_t due_results[$];
    int          errors;

    function new();
      cfg.interface_number = 8'h00;
      cfg.max_lun = 4'h0;
      cfg.in_chunk_limit = msbot_pkg::IN_CHUNK_LIMIT_RESET;
      phase = msbot_pkg::PH_COMMAND;
      saved_tag = '0;
      saved_lun = '0;
      residue = '0;
      remaining = '0;
      direction_in = 1'b0;
      success = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(msbot_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        msbot_pkg::REG_INTERFACE_NUMBER: cfg.interface_number = value[7:0];
        msbot_pkg::REG_MAX_LUN: cfg.max_lun = value[3:0];
        msbot_pkg::REG_IN_CHUNK_LIMIT: cfg.in_chunk_limit = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(msbot_pkg::reg_idx_t idx);
      case (idx)
        msbot_pkg::REG_INTERFACE_NUMBER: return {24'h0, cfg.interface_number};
        msbot_pkg::REG_MAX_LUN: return {28'h0, cfg.max_lun};
        msbot_pkg::REG_IN_CHUNK_LIMIT: return {16'h0, cfg.in_chunk_limit};
        default: return 32'h0;
      endcase
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_item(host_event_t it);
      bot_result_t r;
      logic [31:0] chunk;
      logic        bad;
      r = '{default: '0};
      case (it.op)
        msbot_pkg::OP_SETUP: begin
          if (it.setup_value == 16'h0 && it.setup_index == {8'h0, cfg.interface_number}) begin
            if (it.setup_head[7:0] == msbot_pkg::TYPE_CLASS_OUT &&
                it.setup_head[15:8] == msbot_pkg::REQ_BOMSR && it.length == 16'd0) begin
              phase = msbot_pkg::PH_COMMAND;
              r.handled = 1'b1;
              r.action = msbot_pkg::ACT_RESET_ACK;
            end else if (it.setup_head[7:0] == msbot_pkg::TYPE_CLASS_IN &&
                         it.setup_head[15:8] == msbot_pkg::REQ_GET_MAX_LUN &&
                         it.length == 16'd1) begin
              r.handled = 1'b1;
              r.action = msbot_pkg::ACT_LUN_REPLY;
              r.reply_byte = {4'h0, cfg.max_lun};
            end
          end
        end
        msbot_pkg::OP_BULK_OUT: begin
          if (phase == msbot_pkg::PH_COMMAND) begin
            bad = it.length != msbot_pkg::CBW_SIZE ||
                  it.cbw_signature != msbot_pkg::CBW_SIGNATURE ||
                  (it.cbw_flags[6:0] & msbot_pkg::CBW_RESERVED_MASK) != 7'h0 ||
                  it.cbw_block_length > msbot_pkg::MAX_CB_LENGTH ||
                  it.cbw_lun > {4'h0, cfg.max_lun};
            if (!bad) begin
              success = it.handler_ok;
              saved_tag = it.cbw_tag;
              saved_lun = it.cbw_lun[3:0];
              residue = '0;
              if (it.cbw_transfer_length == 32'h0) begin
                phase = msbot_pkg::PH_STATUS;
              end else begin
                direction_in = it.cbw_flags[msbot_pkg::CBW_DIR_IN_BIT];
                remaining = it.cbw_transfer_length;
                if (success) begin
                  phase = direction_in ? msbot_pkg::PH_DATA_IN : msbot_pkg::PH_DATA_OUT;
                end else begin
                  residue = remaining;
                  phase = direction_in ? msbot_pkg::PH_FAIL_IN : msbot_pkg::PH_FAIL_OUT;
                end
              end
              r.handled = 1'b1;
              r.action = msbot_pkg::ACT_COMMAND;
              r.handler_lun = saved_lun;
            end
          end else if (phase == msbot_pkg::PH_DATA_OUT || phase == msbot_pkg::PH_FAIL_OUT) begin
            r.handled = 1'b1;
            if (phase == msbot_pkg::PH_DATA_OUT) begin
              r.action = msbot_pkg::ACT_OUT_FORWARDED;
              r.handler_lun = saved_lun;
              if (!it.handler_ok) begin
                residue = remaining;
                success = 1'b0;
                phase = msbot_pkg::PH_FAIL_OUT;
              end
            end else begin
              r.action = msbot_pkg::ACT_OUT_DISCARDED;
            end
            // host over-send clamps at zero
            remaining = ({16'h0, it.length} >= remaining) ? 32'h0 :
                        remaining - {16'h0, it.length};
            if (remaining == 32'h0) phase = msbot_pkg::PH_STATUS;
          end
        end
        msbot_pkg::OP_BULK_IN: begin
          if (phase == msbot_pkg::PH_DATA_IN || phase == msbot_pkg::PH_FAIL_IN) begin
            chunk = (remaining > {16'h0, cfg.in_chunk_limit}) ?
                    {16'h0, cfg.in_chunk_limit} : remaining;
            r.handled = 1'b1;
            r.chunk_length = chunk[15:0];
            if (phase == msbot_pkg::PH_DATA_IN) begin
              r.action = msbot_pkg::ACT_IN_DATA;
              r.handler_lun = saved_lun;
              if (!it.handler_ok) begin
                residue = remaining;
                success = 1'b0;
                phase = msbot_pkg::PH_FAIL_IN;
              end
            end else begin
              r.action = msbot_pkg::ACT_IN_FILLER;
            end
            remaining = remaining - chunk;
            if (remaining == 32'h0) phase = msbot_pkg::PH_STATUS;
          end else if (phase == msbot_pkg::PH_STATUS) begin
            r.handled = 1'b1;
            r.action = msbot_pkg::ACT_STATUS;
            r.chunk_length = msbot_pkg::CSW_SIZE;
            r.csw_signature = msbot_pkg::CSW_SIGNATURE;
            r.csw_tag = saved_tag;
            r.csw_residue = residue;
            r.csw_status = !success;
            phase = msbot_pkg::PH_COMMAND;
          end
        end
        default: ;
      endcase
      due_results.push_back(r);
    endfunction

    function string show(bot_result_t r);
      return $sformatf({"handled=%b action=%0d reply=%h chunk=%0d lun=%0d",
                        " sig=%h tag=%h res=%h st=%b"},
                       r.handled, r.action, r.reply_byte, r.chunk_length, r.handler_lun,
                       r.csw_signature, r.csw_tag, r.csw_residue, r.csw_status);
    endfunction

    function void check_result(bot_result_t got);
      bot_result_t want;
      if (due_results.size() == 0) begin
        flag({"result item with nothing outstanding: ", show(got)});
        return;
      end
      want = due_results.pop_front();
      if (got.handled !== want.handled || got.action !== want.action ||
          got.reply_byte !== want.reply_byte || got.chunk_length !== want.chunk_length ||
          got.handler_lun !== want.handler_lun || got.csw_signature !== want.csw_signature ||
          got.csw_tag !== want.csw_tag || got.csw_residue !== want.csw_residue ||
          got.csw_status !== want.csw_status)
        flag({"mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [msbot_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  msbot_req_if req ();
  msbot_rsp_if rsp ();

  bot_phase_tracker board = new();
  int src_idle_pct = 27;
  int sink_idle_pct = 69;
  int hold_requests = 0;

  mass_storage_bulk_only_transport i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic host_event_t rand_event();
    host_event_t it;
    it.op = 2'($urandom());
    it.setup_head = 16'($urandom());
    it.setup_value = 16'($urandom());
    it.setup_index = 16'($urandom());
    it.length = 16'($urandom());
    it.cbw_signature = $urandom();
    it.cbw_tag = $urandom();
    it.cbw_transfer_length = $urandom();
    it.cbw_flags = 8'($urandom());
    it.cbw_lun = 8'($urandom());
    it.cbw_block_length = 8'($urandom());
    it.handler_ok = 1'($urandom());
    return it;
  endfunction

  function automatic host_event_t mk_setup(logic [7:0] rtype, logic [7:0] rcode,
                                           logic [15:0] value, logic [15:0] index,
                                           logic [15:0] len);
    host_event_t it;
    it = rand_event();
    it.op = msbot_pkg::OP_SETUP;
    it.setup_head = {rcode, rtype};
    it.setup_value = value;
    it.setup_index = index;
    it.length = len;
    return it;
  endfunction

  function automatic host_event_t mk_cbw(logic [15:0] len, logic [31:0] sig, logic [31:0] xfer,
                                         logic [7:0] flags, logic [7:0] lun, logic [7:0] cblen,
                                         logic ok);
    host_event_t it;
    it = rand_event();
    it.op = msbot_pkg::OP_BULK_OUT;
    it.length = len;
    it.cbw_signature = sig;
    it.cbw_transfer_length = xfer;
    it.cbw_flags = flags;
    it.cbw_lun = lun;
    it.cbw_block_length = cblen;
    it.handler_ok = ok;
    return it;
  endfunction

  function automatic host_event_t mk_out(logic [15:0] len, logic ok);
    host_event_t it;
    it = rand_event();
    it.op = msbot_pkg::OP_BULK_OUT;
    it.length = len;
    it.handler_ok = ok;
    return it;
  endfunction

  function automatic host_event_t mk_in(logic ok);
    host_event_t it;
    it = rand_event();
    it.op = msbot_pkg::OP_BULK_IN;
    it.handler_ok = ok;
    return it;
  endfunction

  // mostly well-formed traffic for the current phase, with setups and noise mixed in
  function automatic host_event_t next_host_event();
    host_event_t it;
    int unsigned r;
    int unsigned pick;
    logic [31:0] lim;
    logic [31:0] xfer;
    logic [7:0]  flags;
    logic [7:0]  lun;
    logic [7:0]  cblen;
    logic [15:0] intf;
    logic [15:0] mis;
    intf = {8'h0, board.cfg.interface_number};
    mis = board.cfg.in_chunk_limit;
    r = $urandom_range(99);
    if (r < 10) begin
      pick = $urandom_range(4);
      if (pick < 2) begin
        it = mk_setup(msbot_pkg::TYPE_CLASS_OUT, msbot_pkg::REQ_BOMSR, 16'h0, intf, 16'd0);
      end else begin
        it = mk_setup(msbot_pkg::TYPE_CLASS_IN, msbot_pkg::REQ_GET_MAX_LUN, 16'h0, intf,
                      16'd1);
      end
      if (pick > 2) begin
        case ($urandom_range(3))
          0: it.setup_head = 16'($urandom());
          1: it.setup_value = 16'($urandom());
          2: it.setup_index = 16'($urandom());
          default: it.length = 16'($urandom());
        endcase
      end
      return it;
    end
    if (r < 15) return rand_event();
    case (board.phase)
      msbot_pkg::PH_COMMAND: begin
        lim = (mis == 16'd0) ? 32'd16 : ((mis > 16'd128) ? 32'd1024 : {16'h0, mis} * 32'd8);
        pick = $urandom_range(99);
        if (pick < 10) xfer = 32'h0;
        else if (pick < 14) xfer = $urandom();
        else xfer = $urandom_range(lim, 1);
        flags = {1'($urandom()), 7'h0};
        if ($urandom_range(19) == 0) flags[6:0] = 7'($urandom());
        lun = ($urandom_range(19) == 0) ? 8'($urandom()) :
              8'($urandom_range(board.cfg.max_lun));
        cblen = ($urandom_range(19) == 0) ? 8'($urandom()) : 8'($urandom_range(16));
        it = mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, xfer, flags, lun, cblen,
                    $urandom_range(9) != 0);
        if ($urandom_range(19) == 0) it.length = 16'($urandom());
        if ($urandom_range(19) == 0) it.cbw_signature = $urandom();
      end
      msbot_pkg::PH_DATA_OUT, msbot_pkg::PH_FAIL_OUT: begin
        it = mk_out(($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(600)),
                    $urandom_range(9) != 0);
      end
      default: it = mk_in($urandom_range(9) != 0);
    endcase
    return it;
  endfunction

  task automatic send_event(host_event_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= it.op;
    req.setup_head <= it.setup_head;
    req.setup_value <= it.setup_value;
    req.setup_index <= it.setup_index;
    req.length <= it.length;
    req.cbw_signature <= it.cbw_signature;
    req.cbw_tag <= it.cbw_tag;
    req.cbw_transfer_length <= it.cbw_transfer_length;
    req.cbw_flags <= it.cbw_flags;
    req.cbw_lun <= it.cbw_lun;
    req.cbw_block_length <= it.cbw_block_length;
    req.handler_ok <= it.handler_ok;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_item(it);
  endtask

  task automatic apb_access(logic wr, msbot_pkg::reg_idx_t idx, logic [31:0] value,
                            output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= msbot_pkg::PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
  endtask

  task automatic write_reg(msbot_pkg::reg_idx_t idx, logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    board.set_reg(idx, value);
    apb_access(1'b0, idx, 32'h0, rd);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== board.reg_value(idx))
      board.flag($sformatf("register %0d read back %h, expected %h", idx, rd,
                           board.reg_value(idx)));
  endtask

  task automatic quiesce();
    int n;
    req.valid <= 1'b0;
    for (n = 0; n < 2000 && board.pending() != 0; n++) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // result side: check accepted items, random back-pressure, long hold on request
  initial begin : result_sink
    bot_result_t got;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.handled = rsp.handled;
        got.action = rsp.action;
        got.reply_byte = rsp.reply_byte;
        got.chunk_length = rsp.chunk_length;
        got.handler_lun = rsp.handler_lun;
        got.csw_signature = rsp.csw_signature;
        got.csw_tag = rsp.csw_tag;
        got.csw_residue = rsp.csw_residue;
        got.csw_status = rsp.csw_status;
        board.check_result(got);
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = 48;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : host_side
    host_event_t ev;
    int seg;
    int n;
    logic [7:0]  intf;
    logic [3:0]  lun;
    logic [15:0] mis;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.op = '0;
    req.setup_head = '0;
    req.setup_value = '0;
    req.setup_index = '0;
    req.length = '0;
    req.cbw_signature = '0;
    req.cbw_tag = '0;
    req.cbw_transfer_length = '0;
    req.cbw_flags = '0;
    req.cbw_lun = '0;
    req.cbw_block_length = '0;
    req.handler_ok = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, register defaults
    send_event(mk_setup(msbot_pkg::TYPE_CLASS_IN, msbot_pkg::REQ_GET_MAX_LUN, 16'h0, 16'h0,
                        16'd1));
    send_event(mk_setup(msbot_pkg::TYPE_CLASS_IN, msbot_pkg::REQ_GET_MAX_LUN, 16'h0, 16'h0,
                        16'd2));
    ev = rand_event();
    ev.op = OP_UNUSED;
    send_event(ev);
    send_event(mk_in(1'b1));
    // malformed command wrappers
    send_event(mk_cbw(16'd30, msbot_pkg::CBW_SIGNATURE, 32'd8, 8'h00, 8'h00, 8'd0, 1'b1));
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, ~msbot_pkg::CBW_SIGNATURE, 32'd8, 8'h00, 8'h00,
                      8'd0, 1'b1));
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'd8, 8'h7f, 8'h00,
                      8'd0, 1'b1));
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'd8, 8'h00, 8'h00,
                      msbot_pkg::MAX_CB_LENGTH + 8'd1, 1'b1));
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'd8, 8'h00, 8'h01,
                      8'd0, 1'b1));
    // zero transfer length goes straight to status
    ev = mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'd0, 8'h80, 8'h00,
                msbot_pkg::MAX_CB_LENGTH, 1'b1);
    ev.cbw_tag = '1;
    send_event(ev);
    send_event(mk_in(1'b0));
    // data out, handler fails, host over-sends
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'd100, 8'h00, 8'h00,
                      8'd6, 1'b1));
    send_event(mk_out(16'd40, 1'b1));
    send_event(mk_out(16'hffff, 1'b0));
    send_event(mk_in(1'b1));
    // data in, chunked, handler fails midway
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'd1000, 8'h80, 8'h00,
                      8'd10, 1'b1));
    send_event(mk_in(1'b1));
    send_event(mk_in(1'b0));
    send_event(mk_in(1'b1));
    // failed command, then class reset mid-transfer
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'hffff_ffff, 8'h00,
                      8'h00, 8'd12, 1'b0));
    send_event(mk_out(16'd0, 1'b1));
    send_event(mk_setup(msbot_pkg::TYPE_CLASS_OUT, msbot_pkg::REQ_BOMSR, 16'h0, 16'h0,
                        16'd0));
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'd5, 8'h80, 8'h00,
                      8'd1, 1'b0));
    send_event(mk_in(1'b1));
    send_event(mk_in(1'b1));

    // zero chunk size keeps data in going until a class reset
    quiesce();
    write_reg(msbot_pkg::REG_INTERFACE_NUMBER, 32'h0000_00ff);
    write_reg(msbot_pkg::REG_MAX_LUN, 32'h0000_000f);
    write_reg(msbot_pkg::REG_IN_CHUNK_LIMIT, 32'h0000_0000);
    send_event(mk_setup(msbot_pkg::TYPE_CLASS_IN, msbot_pkg::REQ_GET_MAX_LUN, 16'h0, 16'h00ff,
                        16'd1));
    send_event(mk_setup(msbot_pkg::TYPE_CLASS_OUT, msbot_pkg::REQ_BOMSR, 16'h0001, 16'h00ff,
                        16'd0));
    send_event(mk_cbw(msbot_pkg::CBW_SIZE, msbot_pkg::CBW_SIGNATURE, 32'd10, 8'h80, 8'h0f,
                      8'd16, 1'b1));
    send_event(mk_in(1'b1));
    send_event(mk_in(1'b1));
    send_event(mk_setup(msbot_pkg::TYPE_CLASS_OUT, msbot_pkg::REQ_BOMSR, 16'h0, 16'h00ff,
                        16'd0));

    // random part, one register setting per segment
    for (seg = 0; seg < 6; seg++) begin
      quiesce();
      case (seg)
        0: begin
          intf = 8'h5a; lun = 4'hf; mis = 16'd64;
        end
        1: begin
          intf = 8'hff; lun = 4'h0; mis = 16'd1;
        end
        2: begin
          intf = 8'h00; lun = 4'h7; mis = 16'hffff;
        end
        3: begin
          intf = 8'($urandom()); lun = 4'($urandom()); mis = 16'($urandom_range(2000, 1));
        end
        4: begin
          intf = 8'h01; lun = 4'h3; mis = msbot_pkg::IN_CHUNK_LIMIT_RESET;
        end
        default: begin
          intf = 8'($urandom()); lun = 4'hf; mis = 16'd13;
        end
      endcase
      write_reg(msbot_pkg::REG_INTERFACE_NUMBER, {24'h0, intf});
      write_reg(msbot_pkg::REG_MAX_LUN, {28'h0, lun});
      write_reg(msbot_pkg::REG_IN_CHUNK_LIMIT, {16'h0, mis});
      if (seg < 2) begin
        src_idle_pct = 27; sink_idle_pct = 69;
      end else if (seg < 4) begin
        src_idle_pct = 69; sink_idle_pct = 27;
      end else begin
        src_idle_pct = 0; sink_idle_pct = 0;
      end
      for (n = 0; n < 84; n++) begin
        if (seg == 4 && n == 20) hold_requests++;
        send_event(next_host_event());
      end
    end

    quiesce();
    if (board.pending() != 0)
      board.flag($sformatf("%0d result items never arrived", board.pending()));
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/msbot_pkg.sv
hdl/msbot_req_if.sv
hdl/msbot_rsp_if.sv
hdl/msbot_regs.sv
hdl/mass_storage_bulk_only_transport.sv
hdl/msbot_checker.sv
test/mass_storage_bulk_only_transport_tb.sv
